@@ design/uart_rmf_pkg.sv @@
package uart_rmf_pkg;

  // ring and pull sizing
  localparam int RING_DEPTH = 256;
  localparam int MAX_PULL   = 64;
  localparam int PTR_W      = $clog2(RING_DEPTH);

  // fixed field widths
  localparam int BYTE_W = 8;
  localparam int PULL_W = 7;
  localparam int IRQ_W  = 3;
  localparam int FUNC_W = 2;
  localparam int OFF_W  = 3;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // function codes of an input word
  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_PUSH  = 2'd2,
    FUNC_PULL  = 2'd3
  } func_t;

  // register offsets
  localparam logic [OFF_W-1:0] OFF_DATA    = 3'd0;
  localparam logic [OFF_W-1:0] OFF_STATUS  = 3'd1;
  localparam logic [OFF_W-1:0] OFF_CONTROL = 3'd2;

  // status byte: transmit ready and transmit empty never change
  localparam logic [BYTE_W-1:0] STATUS_BASE = 8'h06;

  // classified operation
  typedef enum logic [2:0] {
    OP_READ_DATA,
    OP_READ_STATUS,
    OP_READ_NONE,
    OP_WRITE_TX,
    OP_WRITE_NONE,
    OP_PUSH,
    OP_PULL
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
    logic              push_last;
    logic [PULL_W-1:0] limit;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic [BYTE_W-1:0] tx_byte;
    logic              tx_valid;
    logic              last;
    logic [IRQ_W-1:0]  irq_out;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_PULL
  } state_t;

  // ring pointer advance with wrap at any depth
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

@@ design/uart_rmf_ram.sv @@
module uart_rmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port; read data holds without re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/uart_rmf_front.sv @@
module uart_rmf_front
  import uart_rmf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [FUNC_W-1:0] func,
  input  logic [OFF_W-1:0]  reg_offset,
  input  logic [BYTE_W-1:0] write_data,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              push_last,
  input  logic [PULL_W-1:0] pull_max,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_pop
);

  cmd_t              classified;
  cmd_t              slots [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_idx;
  logic [QIDX_W-1:0] rd_idx;
  logic [QCNT_W-1:0] count;
  logic              push;

  // classify the incoming word
  always_comb begin
    classified.data      = (func == FUNC_PUSH) ? rx_byte : write_data;
    classified.push_last = push_last;
    classified.limit     = (pull_max > PULL_W'(MAX_PULL)) ? PULL_W'(MAX_PULL) : pull_max;
    case (func)
      FUNC_READ: begin
        if (reg_offset == OFF_DATA) begin
          classified.op = OP_READ_DATA;
        end else if (reg_offset == OFF_STATUS) begin
          classified.op = OP_READ_STATUS;
        end else begin
          classified.op = OP_READ_NONE;
        end
      end
      FUNC_WRITE: begin
        // a write to the control register has no visible effect
        if (reg_offset == OFF_DATA) begin
          classified.op = OP_WRITE_TX;
        end else begin
          classified.op = OP_WRITE_NONE;
        end
      end
      FUNC_PUSH: classified.op = OP_PUSH;
      FUNC_PULL: classified.op = OP_PULL;
      default:   classified.op = OP_READ_NONE;
    endcase
  end

  // queue handshake
  assign item_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign push       = item_valid && !item_stall;
  assign cmd_valid  = (count != '0);
  assign cmd        = slots[rd_idx];

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= (wr_idx == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx + QIDX_W'(1);
      end
      if (cmd_pop) begin
        rd_idx <= (rd_idx == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx + QIDX_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(cmd_pop);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= classified;
    end
  end

endmodule

@@ design/uart_rmf_back.sv @@
module uart_rmf_back
  import uart_rmf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IRQ_W-1:0] cfg_wdata,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_pop,
  input  logic             result_stall,
  output logic             result_valid,
  output result_t          result
);

  state_t            state, state_next;
  logic [PTR_W-1:0]  rx_wp, rx_wp_next;
  logic [PTR_W-1:0]  rx_rp, rx_rp_next;
  logic [PTR_W-1:0]  tx_wp, tx_wp_next;
  logic [PTR_W-1:0]  tx_rp, tx_rp_next;
  logic              rx_ready, rx_ready_next;
  logic [IRQ_W-1:0]  irq_level;
  logic [PULL_W-1:0] pull_left, pull_left_next;
  logic              pull_last, pull_last_next;
  logic              emit_ram, emit_ram_next;
  logic [BYTE_W-1:0] emit_data, emit_data_next;
  logic              res_valid_next;
  result_t           res_next;

  logic              rx_we, rx_re, tx_we, tx_re;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata;
  logic [PTR_W-1:0]  rx_rp_adv, tx_rp_adv;
  logic [IRQ_W-1:0]  irq_now;
  logic              out_free;

  // ring stores
  uart_rmf_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wp),
    .wdata (cmd.data),
    .re    (rx_re),
    .raddr (rx_rp),
    .rdata (rx_rdata)
  );

  uart_rmf_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wp),
    .wdata (cmd.data),
    .re    (tx_re),
    .raddr (tx_rp),
    .rdata (tx_rdata)
  );

  assign rx_rp_adv = ring_next(rx_rp);
  assign tx_rp_adv = ring_next(tx_rp);
  assign irq_now   = rx_ready ? irq_level : '0;
  assign out_free  = !result_valid || !result_stall;

  // sequencer: next state, ring updates and result loading
  always_comb begin
    state_next     = state;
    rx_wp_next     = rx_wp;
    rx_rp_next     = rx_rp;
    tx_wp_next     = tx_wp;
    tx_rp_next     = tx_rp;
    rx_ready_next  = rx_ready;
    pull_left_next = pull_left;
    pull_last_next = pull_last;
    emit_ram_next  = emit_ram;
    emit_data_next = emit_data;
    res_next       = result;
    res_valid_next = result_valid && result_stall;
    cmd_pop        = 1'b0;
    rx_we          = 1'b0;
    rx_re          = 1'b0;
    tx_we          = 1'b0;
    tx_re          = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop        = 1'b1;
          emit_ram_next  = 1'b0;
          emit_data_next = '0;
          state_next     = S_EMIT;
          case (cmd.op)
            OP_READ_DATA: begin
              if (rx_wp != rx_rp) begin
                rx_re         = 1'b1;
                rx_rp_next    = rx_rp_adv;
                emit_ram_next = 1'b1;
                if (rx_rp_adv == rx_wp) begin
                  rx_ready_next = 1'b0;
                end
              end
            end
            OP_READ_STATUS: begin
              emit_data_next = STATUS_BASE | {{(BYTE_W-1){1'b0}}, rx_ready};
            end
            OP_WRITE_TX: begin
              tx_we      = 1'b1;
              tx_wp_next = ring_next(tx_wp);
            end
            OP_PUSH: begin
              rx_we      = 1'b1;
              rx_wp_next = ring_next(rx_wp);
              if (cmd.push_last) begin
                rx_ready_next = 1'b1;
              end
            end
            OP_PULL: begin
              // nothing pending or zero limit falls through to an empty result
              if ((tx_rp != tx_wp) && (cmd.limit != '0)) begin
                tx_re          = 1'b1;
                tx_rp_next     = tx_rp_adv;
                pull_last_next = (cmd.limit == PULL_W'(1)) || (tx_rp_adv == tx_wp);
                pull_left_next = cmd.limit - PULL_W'(1);
                state_next     = S_PULL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          res_valid_next     = 1'b1;
          res_next.read_data = emit_ram ? rx_rdata : emit_data;
          res_next.tx_byte   = '0;
          res_next.tx_valid  = 1'b0;
          res_next.last      = 1'b1;
          res_next.irq_out   = irq_now;
          state_next         = S_IDLE;
        end
      end
      S_PULL: begin
        // hand out the byte from the transmit ring read port and, unless it is the last, fetch the next one
        if (out_free) begin
          res_valid_next     = 1'b1;
          res_next.read_data = '0;
          res_next.tx_byte   = tx_rdata;
          res_next.tx_valid  = 1'b1;
          res_next.last      = pull_last;
          res_next.irq_out   = irq_now;
          if (pull_last) begin
            state_next = S_IDLE;
          end else begin
            tx_re          = 1'b1;
            tx_rp_next     = tx_rp_adv;
            pull_last_next = (pull_left == PULL_W'(1)) || (tx_rp_adv == tx_wp);
            pull_left_next = pull_left - PULL_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rx_wp        <= '0;
      rx_rp        <= '0;
      tx_wp        <= '0;
      tx_rp        <= '0;
      rx_ready     <= 1'b0;
      irq_level    <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      rx_wp        <= rx_wp_next;
      rx_rp        <= rx_rp_next;
      tx_wp        <= tx_wp_next;
      tx_rp        <= tx_rp_next;
      rx_ready     <= rx_ready_next;
      result_valid <= res_valid_next;
      if (cfg_we) begin
        irq_level <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pull_left <= pull_left_next;
    pull_last <= pull_last_next;
    emit_ram  <= emit_ram_next;
    emit_data <= emit_data_next;
    result    <= res_next;
  end

`ifndef SYNTHESIS
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (state == S_IDLE) && cmd_valid)
    else $error("command popped outside idle");

  a_pull_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_PULL) && !pull_last |-> (pull_left != '0))
    else $error("pull continues with no bytes left");

  a_fields_apart: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.tx_valid && (result.read_data != '0)))
    else $error("transmit byte and read data in one word");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result present after reset");
`endif

endmodule

@@ design/uart_register_model_with_fifos_unit.sv @@
// channel   handshake                 payload
// item      item_valid / item_stall   func reg_offset write_data rx_byte push_last pull_max
// result    result_valid / result_stall  read_data tx_byte tx_valid last irq_out
// config    cfg_we                    cfg_wdata (interrupt level)
//
// a read, write or push is popped from the command queue in the idle state, and its word is
// then loaded into the output register from the emit state once that register is free
// a pull starts in idle, then one byte a cycle from the transmit ring read port unless stalled
// the two-entry command queue takes a word every cycle while it has room
// reset is synchronous; ring contents need no clearing as only written entries are read
// result_stall holds the output register and then backs up into the command queue
module uart_register_model_with_fifos_unit
  import uart_rmf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IRQ_W-1:0]  cfg_wdata,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [FUNC_W-1:0] func,
  input  logic [OFF_W-1:0]  reg_offset,
  input  logic [BYTE_W-1:0] write_data,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              push_last,
  input  logic [PULL_W-1:0] pull_max,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [BYTE_W-1:0] read_data,
  output logic [BYTE_W-1:0] tx_byte,
  output logic              tx_valid,
  output logic              last,
  output logic [IRQ_W-1:0]  irq_out
);

  logic    cmd_valid;
  logic    cmd_pop;
  cmd_t    cmd;
  result_t result;

  // accept and classify
  uart_rmf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .func       (func),
    .reg_offset (reg_offset),
    .write_data (write_data),
    .rx_byte    (rx_byte),
    .push_last  (push_last),
    .pull_max   (pull_max),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  // rings, status and result word
  uart_rmf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

  assign read_data = result.read_data;
  assign tx_byte   = result.tx_byte;
  assign tx_valid  = result.tx_valid;
  assign last      = result.last;
  assign irq_out   = result.irq_out;

endmodule

@@ dv/uart_register_model_with_fifos_unit_tb.sv @@
`timescale 1ns / 1ps

module uart_register_model_with_fifos_unit_tb;
  import uart_rmf_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int TAIL_CYCLES = 16;
  localparam int MISMATCH_PRINT_CAP = 40;

  // offset that decodes to no register
  localparam logic [OFF_W-1:0] OFF_UNUSED = 3'd7;
  localparam logic [BYTE_W-1:0] RX_READY_BIT = 8'h01;

  typedef struct packed {
    func_t             func;
    logic [OFF_W-1:0]  offset;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] rxb;
    logic              plast;
    logic [PULL_W-1:0] pmax;
  } uart_word_t;

  typedef struct packed {
    uart_word_t word;
    logic       typed;
    result_t    want;
  } probe_row_t;

  // directed words; typed rows carry their outcome at irq level 7
  localparam probe_row_t PROBE_ROWS [25] = '{
    '{'{FUNC_READ,  OFF_STATUS,  8'h00, 8'h00, 1'b0, 7'd0},   1'b1, '{8'h06, 8'h00, 1'b0, 1'b1, 3'd0}},
    '{'{FUNC_READ,  OFF_DATA,    8'h00, 8'h00, 1'b0, 7'd0},   1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 3'd0}},
    '{'{FUNC_READ,  OFF_CONTROL, 8'h00, 8'h00, 1'b0, 7'd0},   1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 3'd0}},
    '{'{FUNC_READ,  OFF_UNUSED,  8'hff, 8'hff, 1'b1, 7'd127}, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 3'd0}},
    '{'{FUNC_PULL,  OFF_DATA,    8'h00, 8'h00, 1'b0, 7'd5},   1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 3'd0}},
    '{'{FUNC_WRITE, OFF_CONTROL, 8'hff, 8'h00, 1'b0, 7'd0},   1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 3'd0}},
    '{'{FUNC_WRITE, OFF_STATUS,  8'haa, 8'h00, 1'b0, 7'd0},   1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 3'd0}},
    '{'{FUNC_WRITE, OFF_UNUSED,  8'h55, 8'h00, 1'b0, 7'd0},   1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 3'd0}},
    '{'{FUNC_WRITE, OFF_DATA,    8'h00, 8'hff, 1'b1, 7'd0},   1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 3'd0}},
    '{'{FUNC_WRITE, OFF_DATA,    8'hff, 8'h00, 1'b0, 7'd0},   1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 3'd0}},
    '{'{FUNC_WRITE, OFF_DATA,    8'ha5, 8'h00, 1'b0, 7'd0},   1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 3'd0}},
    '{'{FUNC_PULL,  OFF_DATA,    8'h00, 8'h00, 1'b0, 7'd0},   1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 3'd0}},
    '{'{FUNC_PULL,  OFF_DATA,    8'h00, 8'h00, 1'b0, 7'd2},   1'b0, '0},
    '{'{FUNC_PULL,  OFF_UNUSED,  8'hff, 8'hff, 1'b1, 7'd127}, 1'b0, '0},
    '{'{FUNC_PUSH,  OFF_DATA,    8'h00, 8'hff, 1'b0, 7'd0},   1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 3'd0}},
    '{'{FUNC_READ,  OFF_STATUS,  8'h00, 8'h00, 1'b0, 7'd0},   1'b1, '{8'h06, 8'h00, 1'b0, 1'b1, 3'd0}},
    '{'{FUNC_PUSH,  OFF_DATA,    8'hff, 8'h00, 1'b1, 7'd0},   1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 3'd7}},
    '{'{FUNC_READ,  OFF_STATUS,  8'h00, 8'h00, 1'b0, 7'd0},   1'b1, '{8'h07, 8'h00, 1'b0, 1'b1, 3'd7}},
    '{'{FUNC_READ,  OFF_DATA,    8'h00, 8'h00, 1'b0, 7'd0},   1'b1, '{8'hff, 8'h00, 1'b0, 1'b1, 3'd7}},
    '{'{FUNC_READ,  OFF_DATA,    8'h00, 8'h00, 1'b0, 7'd0},   1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 3'd0}},
    '{'{FUNC_READ,  OFF_DATA,    8'h00, 8'h00, 1'b0, 7'd0},   1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 3'd0}},
    '{'{FUNC_READ,  OFF_CONTROL, 8'h00, 8'h00, 1'b0, 7'd0},   1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 3'd0}},
    '{'{FUNC_PUSH,  OFF_STATUS,  8'h00, 8'h5a, 1'b1, 7'd64},  1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 3'd7}},
    '{'{FUNC_PULL,  OFF_DATA,    8'h00, 8'h00, 1'b0, 7'd64},  1'b1, '{8'h00, 8'h00, 1'b0, 1'b1, 3'd7}},
    '{'{FUNC_READ,  OFF_DATA,    8'h00, 8'h00, 1'b0, 7'd0},   1'b1, '{8'h5a, 8'h00, 1'b0, 1'b1, 3'd0}}
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [IRQ_W-1:0]  cfg_wdata;
  logic              item_valid;
  logic              item_stall;
  logic [FUNC_W-1:0] func;
  logic [OFF_W-1:0]  reg_offset;
  logic [BYTE_W-1:0] write_data;
  logic [BYTE_W-1:0] rx_byte;
  logic              push_last;
  logic [PULL_W-1:0] pull_max;
  logic              result_valid;
  logic              result_stall;
  logic [BYTE_W-1:0] read_data;
  logic [BYTE_W-1:0] tx_byte;
  logic              tx_valid;
  logic              last;
  logic [IRQ_W-1:0]  irq_out;

  // uart state mirrored by the testbench
  logic [BYTE_W-1:0] rx_ring [RING_DEPTH];
  logic [BYTE_W-1:0] tx_ring [RING_DEPTH];
  logic [PTR_W-1:0]  rx_wr, rx_rd, tx_wr, tx_rd;
  logic [BYTE_W-1:0] status_byte;
  logic [BYTE_W-1:0] ctrl_byte;
  logic [IRQ_W-1:0]  irq_lvl;

  result_t uart_outputs_due [$];

  int  words_sent;
  int  results_seen;
  int  mismatches;
  int  levels_used;
  int  holds_done;
  int  idle_run;
  bit  feed_back_to_back;
  bit  drain_back_to_back;
  bit  hold_off_req;

  uart_register_model_with_fifos_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .reg_offset   (reg_offset),
    .write_data   (write_data),
    .rx_byte      (rx_byte),
    .push_last    (push_last),
    .pull_max     (pull_max),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .read_data    (read_data),
    .tx_byte      (tx_byte),
    .tx_valid     (tx_valid),
    .last         (last),
    .irq_out      (irq_out)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // expected outcome word, irq level taken from the state after the access
  function automatic void queue_outcome(input logic [BYTE_W-1:0] rd, input logic [BYTE_W-1:0] tb,
                                        input logic tv, input logic lst);
    result_t r;
    r.read_data = rd;
    r.tx_byte   = tb;
    r.tx_valid  = tv;
    r.last      = lst;
    r.irq_out   = (status_byte & RX_READY_BIT) != '0 ? irq_lvl : '0;
    uart_outputs_due.push_back(r);
  endfunction

  function automatic void reset_uart_mirror();
    for (int i = 0; i < RING_DEPTH; i++) begin
      rx_ring[i] = '0;
      tx_ring[i] = '0;
    end
    rx_wr = '0;
    rx_rd = '0;
    tx_wr = '0;
    tx_rd = '0;
    status_byte = STATUS_BASE;
    ctrl_byte = '0;
    irq_lvl = '0;
  endfunction

  // advance the mirror by one accepted word and queue its outcome words
  function automatic void step_uart_mirror(input uart_word_t w);
    int unsigned       limit;
    int unsigned       taken;
    logic [BYTE_W-1:0] rd;
    logic [BYTE_W-1:0] b;
    rd = '0;
    taken = 0;
    case (w.func)
      FUNC_READ: begin
        if (w.offset == OFF_STATUS) begin
          rd = status_byte;
        end else if (w.offset == OFF_DATA && rx_wr != rx_rd) begin
          rd = rx_ring[rx_rd];
          rx_rd = rx_rd + 1'b1;
          // draining the ring drops receive-ready
          if (rx_wr == rx_rd) status_byte = status_byte & ~RX_READY_BIT;
        end
        queue_outcome(rd, '0, 1'b0, 1'b1);
      end
      FUNC_WRITE: begin
        if (w.offset == OFF_DATA) begin
          tx_ring[tx_wr] = w.wdata;
          tx_wr = tx_wr + 1'b1;
        end else if (w.offset == OFF_CONTROL) begin
          ctrl_byte = w.wdata;
        end
        queue_outcome('0, '0, 1'b0, 1'b1);
      end
      FUNC_PUSH: begin
        // a full ring still takes the byte and wraps
        rx_ring[rx_wr] = w.rxb;
        rx_wr = rx_wr + 1'b1;
        if (w.plast) status_byte = status_byte | RX_READY_BIT;
        queue_outcome('0, '0, 1'b0, 1'b1);
      end
      default: begin
        limit = (w.pmax > MAX_PULL) ? MAX_PULL : w.pmax;
        while (tx_rd != tx_wr && taken < limit) begin
          b = tx_ring[tx_rd];
          tx_rd = tx_rd + 1'b1;
          taken++;
          queue_outcome('0, b, 1'b1, (tx_rd == tx_wr) || (taken >= limit));
        end
        // nothing pending or zero limit gives a single empty word
        if (taken == 0) queue_outcome('0, '0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  function automatic uart_word_t make_word(input func_t f, input logic [OFF_W-1:0] off);
    uart_word_t w;
    w.func   = f;
    w.offset = off;
    w.wdata  = BYTE_W'($urandom_range(0, 255));
    w.rxb    = BYTE_W'($urandom_range(0, 255));
    w.plast  = 1'($urandom_range(0, 1));
    w.pmax   = PULL_W'($urandom_range(0, 127));
    return w;
  endfunction

  function automatic uart_word_t any_word();
    return make_word(func_t'($urandom_range(0, 3)), OFF_W'($urandom_range(0, 7)));
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MISMATCH_PRINT_CAP) $display("mismatch at %0t: %s", $time, what);
  endtask

  // offer one word and wait for the block to take it
  task automatic send_word(input uart_word_t w);
    int gap;
    gap = feed_back_to_back ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    func       <= w.func;
    reg_offset <= w.offset;
    write_data <= w.wdata;
    rx_byte    <= w.rxb;
    push_last  <= w.plast;
    pull_max   <= w.pmax;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    step_uart_mirror(w);
    words_sent++;
  endtask

  // sender goes quiet until every outcome has come back
  task automatic wait_until_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (uart_outputs_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic load_irq_level(input logic [IRQ_W-1:0] lvl);
    cfg_we    <= 1'b1;
    cfg_wdata <= lvl;
    @(posedge clk);
    cfg_we <= 1'b0;
    irq_lvl = lvl;
    levels_used++;
    @(posedge clk);
  endtask

  // random traffic, mostly well-formed bursts with some noise mixed in
  task automatic run_traffic(input int n);
    int         start;
    int         k;
    int         pick;
    uart_word_t w;
    start = words_sent;
    while (words_sent - start < n) begin
      pick = $urandom_range(0, 9);
      if (pick <= 2) begin
        // short transmit burst then a pull
        k = $urandom_range(1, 12);
        repeat (k) send_word(make_word(FUNC_WRITE, OFF_DATA));
        send_word(make_word(FUNC_PULL, OFF_W'($urandom_range(0, 7))));
      end else if (pick <= 5) begin
        // receive batch closed by last, then read it back
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++) begin
          w = make_word(FUNC_PUSH, OFF_W'($urandom_range(0, 7)));
          w.plast = (i == k - 1) || ($urandom_range(0, 7) == 0);
          send_word(w);
        end
        for (int i = 0; i <= k; i++) begin
          if ($urandom_range(0, 5) == 0) send_word(make_word(FUNC_READ, OFF_STATUS));
          send_word(make_word(FUNC_READ, OFF_DATA));
        end
      end else if (pick <= 7) begin
        repeat ($urandom_range(1, 4)) send_word(any_word());
      end else if (pick == 8) begin
        send_word(make_word(FUNC_WRITE, OFF_CONTROL));
        send_word(make_word(FUNC_READ, OFF_CONTROL));
        send_word(make_word(FUNC_READ, OFF_STATUS));
        send_word(make_word(func_t'($urandom_range(0, 1)), OFF_W'($urandom_range(3, 7))));
      end else begin
        repeat ($urandom_range(1, 3)) send_word(make_word(FUNC_PULL, OFF_DATA));
      end
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int      wait_cycles;
    result_t want;
    result_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      wait_cycles = drain_back_to_back ? 0 : $urandom_range(0, 10);
      if (hold_off_req) begin
        wait_cycles = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
        holds_done++;
      end
      if (wait_cycles > 0) begin
        result_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      results_seen++;
      if (uart_outputs_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word read_data %02h tx_byte %02h tx_valid %0b",
                                  read_data, tx_byte, tx_valid));
      end else begin
        want = uart_outputs_due.pop_front();
        if (read_data !== want.read_data)
          report_mismatch($sformatf("read_data %02h, expected %02h", read_data, want.read_data));
        if (tx_byte !== want.tx_byte)
          report_mismatch($sformatf("tx_byte %02h, expected %02h", tx_byte, want.tx_byte));
        if (tx_valid !== want.tx_valid)
          report_mismatch($sformatf("tx_valid %0b, expected %0b", tx_valid, want.tx_valid));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
        if (irq_out !== want.irq_out)
          report_mismatch($sformatf("irq_out %0d, expected %0d", irq_out, want.irq_out));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_run = 0;
    end else begin
      idle_run++;
    end
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("no handshake for %0d cycles, %0d words still expected", idle_run,
               uart_outputs_due.size());
      $display("uart_register_model_with_fifos_unit verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    uart_word_t w;
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    item_valid <= 1'b0;
    func       <= FUNC_READ;
    reg_offset <= OFF_DATA;
    write_data <= '0;
    rx_byte    <= '0;
    push_last  <= 1'b0;
    pull_max   <= '0;
    reset_uart_mirror();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words at the top irq level
    load_irq_level(3'd7);
    foreach (PROBE_ROWS[i]) begin
      send_word(PROBE_ROWS[i].word);
      if (PROBE_ROWS[i].typed) begin
        void'(uart_outputs_due.pop_back());
        uart_outputs_due.push_back(PROBE_ROWS[i].want);
      end
    end
    wait_until_drained();

    // random traffic with interrupts masked to level 0
    load_irq_level(3'd0);
    run_traffic(25);
    wait_until_drained();

    // receiver holds off while words keep coming, so the block backs up
    load_irq_level(IRQ_W'($urandom_range(1, 6)));
    feed_back_to_back = 1'b1;
    hold_off_req = 1'b1;
    repeat (20) send_word(make_word(FUNC_WRITE, OFF_DATA));
    w = make_word(FUNC_PULL, OFF_DATA);
    w.pmax = 7'd127;
    send_word(w);
    run_traffic(6);
    feed_back_to_back = 1'b0;
    wait_until_drained();

    load_irq_level(3'd3);
    run_traffic(20);
    wait_until_drained();

    // full-length pull and its remainder, with no idling on either side
    load_irq_level(3'd5);
    feed_back_to_back = 1'b1;
    drain_back_to_back = 1'b1;
    repeat (MAX_PULL + 1) send_word(make_word(FUNC_WRITE, OFF_DATA));
    w = make_word(FUNC_PULL, OFF_DATA);
    w.pmax = PULL_W'(MAX_PULL);
    send_word(w);
    send_word(make_word(FUNC_WRITE, OFF_DATA));
    send_word(w);
    feed_back_to_back = 1'b0;
    drain_back_to_back = 1'b0;
    wait_until_drained();

    $display("covered %0d input words and %0d result words over %0d irq level settings",
             words_sent, results_seen, levels_used);
    $display("receiver hold-offs %0d, full-length pull back to back, %0d mismatches",
             holds_done, mismatches);
    if (mismatches == 0) begin
      $display("uart_register_model_with_fifos_unit verification clean");
    end else begin
      $display("uart_register_model_with_fifos_unit verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/uart_rmf_pkg.sv
design/uart_rmf_ram.sv
design/uart_rmf_front.sv
design/uart_rmf_back.sv
design/uart_register_model_with_fifos_unit.sv
dv/uart_register_model_with_fifos_unit_tb.sv
